// ----- hw/rtl/fpba_pkg.sv -----
`timescale 1ns / 1ps
package fpba_pkg;

  // partition table geometry
  localparam int NumBlocks = 16;
  localparam int IdxW      = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int CntW      = $clog2(NumBlocks + 1);
  localparam int SizeW     = 16;

  // configuration register widths
  localparam int ModeW     = 2;
  localparam int CountW    = 5;
  localparam int ApbDataW  = 32;
  localparam int ApbAddrW  = 3;

  // fit modes
  localparam logic [ModeW-1:0] FitFirst = 2'd0;
  localparam logic [ModeW-1:0] FitBest  = 2'd1;
  localparam logic [ModeW-1:0] FitWorst = 2'd2;

  // register indexes, taken from paddr[2]
  localparam logic RegFitMode    = 1'b0;
  localparam logic RegBlockCount = 1'b1;

  // request types
  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqAlloc = 1'b1;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [ModeW-1:0]  fit_mode;
    logic [CountW-1:0] block_count;
  } cfg_t;

  // access to the free-size memory
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [SizeW-1:0] wdata;
    logic             re;
    logic [IdxW-1:0]  raddr;
  } mem_req_t;

endpackage

// ----- hw/rtl/fpba_if.sv -----
`timescale 1ns / 1ps
// request channel
interface fpba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [3:0]                 block_index;
  logic [fpba_pkg::SizeW-1:0] size_value;

  modport source (output valid, req_type, block_index, size_value, input ready);
  modport sink (input valid, req_type, block_index, size_value, output ready);
endinterface

// result channel
interface fpba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       granted;
  logic [3:0]                 chosen_block;
  logic [fpba_pkg::SizeW-1:0] left_over;

  modport source (output valid, granted, chosen_block, left_over, input ready);
  modport sink (input valid, granted, chosen_block, left_over, output ready);
endinterface

// ----- hw/rtl/fpba_cfg.sv -----
`timescale 1ns / 1ps
module fpba_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpba_pkg::ApbAddrW-1:0]    paddr,
  input  logic [fpba_pkg::ApbDataW-1:0]    pwdata,
  output logic [fpba_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  output fpba_pkg::cfg_t                   cfg_o
);

  logic [fpba_pkg::ModeW-1:0]  fit_mode_q, fit_mode_d;
  logic [fpba_pkg::CountW-1:0] block_count_q, block_count_d;
  logic                        wr_en;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  // register write decode
  always_comb begin
    fit_mode_d    = fit_mode_q;
    block_count_d = block_count_q;
    if (wr_en) begin
      case (reg_sel)
        fpba_pkg::RegFitMode:    fit_mode_d = pwdata[fpba_pkg::ModeW-1:0];
        fpba_pkg::RegBlockCount: block_count_d = pwdata[fpba_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= fpba_pkg::FitFirst;
      block_count_q <= fpba_pkg::CountW'(16);
    end else begin
      fit_mode_q    <= fit_mode_d;
      block_count_q <= block_count_d;
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      fpba_pkg::RegFitMode:
        prdata = {{(fpba_pkg::ApbDataW - fpba_pkg::ModeW){1'b0}}, fit_mode_q};
      fpba_pkg::RegBlockCount:
        prdata = {{(fpba_pkg::ApbDataW - fpba_pkg::CountW){1'b0}}, block_count_q};
      default: prdata = '0;
    endcase
  end

  assign cfg_o.fit_mode    = fit_mode_q;
  assign cfg_o.block_count = block_count_q;

endmodule

// ----- hw/rtl/fpba_mem.sv -----
`timescale 1ns / 1ps
module fpba_mem (
  input  logic                       clk_i,
  input  fpba_pkg::mem_req_t         mem_req_i,
  output logic [fpba_pkg::SizeW-1:0] rdata_o
);

  logic [fpba_pkg::SizeW-1:0] mem_q [fpba_pkg::NumBlocks];
  logic [fpba_pkg::SizeW-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.waddr] <= mem_req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fpba_ctrl.sv -----
`timescale 1ns / 1ps
module fpba_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fpba_pkg::cfg_t             cfg_i,
  fpba_req_if.sink                   req,
  fpba_rsp_if.source                 rsp,
  output fpba_pkg::mem_req_t         mem_req_o,
  input  logic [fpba_pkg::SizeW-1:0] mem_rdata_i
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [fpba_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [fpba_pkg::CntW-1:0]    limit_q, limit_d;
  logic [fpba_pkg::ModeW-1:0]   mode_q, mode_d;
  logic [fpba_pkg::SizeW-1:0]   size_q, size_d;
  logic                         rd_vld_q, rd_vld_d;
  logic [fpba_pkg::IdxW-1:0]    rd_idx_q, rd_idx_d;
  logic                         found_q, found_d;
  logic [fpba_pkg::IdxW-1:0]    pick_q, pick_d;
  logic [fpba_pkg::SizeW-1:0]   pick_val_q, pick_val_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_granted_q, out_granted_d;
  logic [3:0]                   out_block_q, out_block_d;
  logic [fpba_pkg::SizeW-1:0]   out_left_q, out_left_d;

  logic                         accept;
  logic                         issue;
  logic                         fits;
  logic                         better;
  logic                         take;
  logic                         out_free;
  logic [fpba_pkg::SizeW-1:0]   remain;
  logic [fpba_pkg::CntW-1:0]    count_ext;

  assign req.ready = (state_q == StIdle);
  assign accept    = req.valid & req.ready;
  assign issue     = (state_q == StScan) && (cnt_q < limit_q);
  assign out_free  = !out_valid_q || rsp.ready;
  assign remain    = pick_val_q - size_q;

  // block count saturates at the table depth
  always_comb begin
    if (fpba_pkg::CountW > fpba_pkg::CntW) begin
      count_ext = (cfg_i.block_count > fpba_pkg::CountW'(fpba_pkg::NumBlocks))
                  ? fpba_pkg::CntW'(fpba_pkg::NumBlocks)
                  : fpba_pkg::CntW'(cfg_i.block_count);
    end else begin
      count_ext = (fpba_pkg::CntW'(cfg_i.block_count) >
                   fpba_pkg::CntW'(fpba_pkg::NumBlocks))
                  ? fpba_pkg::CntW'(fpba_pkg::NumBlocks)
                  : fpba_pkg::CntW'(cfg_i.block_count);
    end
  end

  // candidate compare on the returning read data
  assign fits = (mem_rdata_i >= size_q);
  always_comb begin
    case (mode_q)
      fpba_pkg::FitBest:  better = (mem_rdata_i < pick_val_q);
      fpba_pkg::FitWorst: better = (mem_rdata_i > pick_val_q);
      default:            better = 1'b0;
    endcase
  end
  assign take = rd_vld_q && fits && (!found_q || better);

  // sequencer
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    limit_d       = limit_q;
    mode_d        = mode_q;
    size_d        = size_q;
    rd_vld_d      = issue;
    rd_idx_d      = cnt_q[fpba_pkg::IdxW-1:0];
    found_d       = found_q;
    pick_d        = pick_q;
    pick_val_d    = pick_val_q;
    out_valid_d   = out_valid_q & ~rsp.ready;
    out_granted_d = out_granted_q;
    out_block_d   = out_block_q;
    out_left_d    = out_left_q;
    mem_req_o     = '0;
    mem_req_o.re    = issue;
    mem_req_o.raddr = cnt_q[fpba_pkg::IdxW-1:0];

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (req.req_type == fpba_pkg::ReqLoad) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = req.block_index[fpba_pkg::IdxW-1:0];
            mem_req_o.wdata = req.size_value;
          end else begin
            state_d = StScan;
            cnt_d   = '0;
            limit_d = count_ext;
            mode_d  = cfg_i.fit_mode;
            size_d  = req.size_value;
            found_d = 1'b0;
          end
        end
      end
      StScan: begin
        if (issue) begin
          cnt_d = cnt_q + fpba_pkg::CntW'(1);
        end
        if (take) begin
          found_d    = 1'b1;
          pick_d     = rd_idx_q;
          pick_val_d = mem_rdata_i;
        end
        if (!issue && !rd_vld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          mem_req_o.we    = found_q;
          mem_req_o.waddr = pick_q;
          mem_req_o.wdata = remain;
          out_valid_d     = 1'b1;
          out_granted_d   = found_q;
          out_block_d     = found_q ? 4'(pick_q) : 4'd0;
          out_left_d      = found_q ? remain : '0;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    limit_q       <= limit_d;
    mode_q        <= mode_d;
    size_q        <= size_d;
    rd_idx_q      <= rd_idx_d;
    pick_q        <= pick_d;
    pick_val_q    <= pick_val_d;
    out_granted_q <= out_granted_d;
    out_block_q   <= out_block_d;
    out_left_q    <= out_left_d;
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.granted      = out_granted_q;
  assign rsp.chosen_block = out_block_q;
  assign rsp.left_over    = out_left_q;

endmodule

// ----- hw/rtl/fit_policy_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// Partition allocator with first, best and worst fit.
// req_i: valid/ready request channel. A load transaction (req_type 0) writes
//   the free size of partition block_index and gives no
//   result. An allocate transaction (req_type 1) searches partitions
//   0 .. min(block_count, 16)-1 and gives exactly one result on rsp_o.
// rsp_o: valid/ready result channel with granted, chosen_block, left_over.
// APB port: register 0 fit_mode at 0x0, register 1 block_count at 0x4;
//   write only while the unit is idle.
// Operation: an allocate occupies the unit from the moment it is taken until
//   its result is registered: the free sizes sit in a synchronous memory read
//   one entry per cycle, followed by the read latency, a step to close the scan
//   and the write-back. A new request can be taken as soon as the result is
//   registered.
// Reset clears the sequencer and the result valid; the free-size memory is
//   not cleared and every partition in use must be loaded first.
// A stalled result holds in the output register; the unit keeps taking
//   requests but an allocate waits at write-back until the register frees.
module fit_policy_block_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fpba_req_if.sink                      req_i,
  fpba_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpba_pkg::ApbAddrW-1:0] paddr,
  input  logic [fpba_pkg::ApbDataW-1:0] pwdata,
  output logic [fpba_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  fpba_pkg::cfg_t             cfg;
  fpba_pkg::mem_req_t         mem_req;
  logic [fpba_pkg::SizeW-1:0] mem_rdata;

  // configuration registers
  fpba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // scan sequencer and result register
  fpba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req         (req_i),
    .rsp         (rsp_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // free-size table
  fpba_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  // a load transaction goes straight to the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.req_type == fpba_pkg::ReqLoad) |->
      (mem_req.we && mem_req.waddr == req_i.block_index[fpba_pkg::IdxW-1:0]
       && mem_req.wdata == req_i.size_value))
    else $error("load transaction not written to the table");

  // a write-back shows up as a granted result with the same remainder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && !req_i.ready) |=>
      (rsp_o.valid && rsp_o.granted && rsp_o.left_over == $past(mem_req.wdata)))
    else $error("write-back without matching result");

  // a new result only comes out of a busy search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(!req_i.ready))
    else $error("result raised while idle");

  // no table read while a request can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !mem_req.re)
    else $error("table read while idle");

endmodule

// ----- sim/fpba_alloc_checker.sv -----
`timescale 1ns / 1ps
module fpba_alloc_checker
  import fpba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  fpba_req_if                 req_mon,
  fpba_rsp_if                 rsp_mon,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output int                  err_count,
  output int                  pending
);

  // one predicted allocation outcome
  typedef struct packed {
    logic             granted;
    logic [3:0]       chosen_block;
    logic [SizeW-1:0] left_over;
  } grant_t;

  // shadow of the partition table and the registers
  logic [SizeW-1:0]  part_free [NumBlocks];
  logic [ModeW-1:0]  cur_mode;
  logic [CountW-1:0] cur_count;
  grant_t            expected_grants [$];

  // one line per mismatch, log kept short on a badly broken run
  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 200) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // search current free sizes, take the request from the winner
  function automatic grant_t allocate_part(input logic [SizeW-1:0] want);
    grant_t res;
    int     limit;
    int     pick;
    bit     found;
    bit     done;
    res   = '0;
    pick  = 0;
    found = 1'b0;
    done  = 1'b0;
    limit = (int'(cur_count) > NumBlocks) ? NumBlocks : int'(cur_count);
    for (int i = 0; i < limit; i++) begin
      if (!done && part_free[i] >= want) begin
        if (!found) begin
          found = 1'b1;
          pick  = i;
          // first fit and the unused mode stop at the first hit
          done  = (cur_mode != FitBest) && (cur_mode != FitWorst);
        end else if (cur_mode == FitBest && part_free[i] < part_free[pick]) begin
          pick = i;
        end else if (cur_mode == FitWorst && part_free[i] > part_free[pick]) begin
          pick = i;
        end
      end
    end
    if (found) begin
      part_free[pick]  = part_free[pick] - want;
      res.granted      = 1'b1;
      res.chosen_block = pick[3:0];
      res.left_over    = part_free[pick];
    end
    return res;
  endfunction

  // watch all three ports at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t want;
    if (!rst_ni) begin
      cur_mode  = FitFirst;
      cur_count = CountW'(NumBlocks);
      expected_grants.delete();
    end else begin
      // result transaction against the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_grants.size() == 0) begin
          flag_error($sformatf("unexpected result granted=%0b block=%0d left=%0d",
                               rsp_mon.granted, rsp_mon.chosen_block, rsp_mon.left_over));
        end else begin
          want = expected_grants.pop_front();
          if (rsp_mon.granted !== want.granted) begin
            flag_error($sformatf("granted %0b, expected %0b", rsp_mon.granted, want.granted));
          end
          if (rsp_mon.chosen_block !== want.chosen_block) begin
            flag_error($sformatf("chosen_block %0d, expected %0d",
                                 rsp_mon.chosen_block, want.chosen_block));
          end
          if (rsp_mon.left_over !== want.left_over) begin
            flag_error($sformatf("left_over %0d, expected %0d",
                                 rsp_mon.left_over, want.left_over));
          end
        end
      end
      // request transaction updates the shadow table
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.req_type == ReqLoad) begin
          part_free[req_mon.block_index] = req_mon.size_value;
        end else begin
          expected_grants.push_back(allocate_part(req_mon.size_value));
        end
      end
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          RegFitMode:    cur_mode  = pwdata[ModeW-1:0];
          RegBlockCount: cur_count = pwdata[CountW-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_grants.size();
  end

endmodule

// ----- sim/tb_fit_policy_block_allocator_unit.sv -----
`timescale 1ns / 1ps
module tb_fit_policy_block_allocator_unit;
  import fpba_pkg::*;

  localparam logic [ModeW-1:0] FitUnused = 2'd3;
  localparam int CountMax     = (1 << CountW) - 1;
  localparam int SettleCycles = 24;
  localparam int QuietLimit   = 2000;
  localparam int NumPhases    = 12;
  localparam int PhaseItems   = 45;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  bit                  stall_on;
  int                  err_count;
  int                  pending;
  int                  quiet_cycles;

  fpba_req_if req_ch ();
  fpba_rsp_if rsp_ch ();

  fit_policy_block_allocator_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fpba_alloc_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_mon   (req_ch),
    .rsp_mon   (rsp_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .err_count (err_count),
    .pending   (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result back-pressure in short bursts
  initial begin
    rsp_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // apb write: setup then access
  task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [ModeW-1:0] mode, input logic [CountW-1:0] count);
    apb_write({RegFitMode, 2'b00}, ApbDataW'(mode));
    apb_write({RegBlockCount, 2'b00}, ApbDataW'(count));
  endtask

  // one request transaction, with an optional gap in front
  task automatic send_item(input logic rtype, input logic [3:0] idx,
                           input logic [SizeW-1:0] sz);
    @(negedge clk);
    if (stall_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.req_type    = rtype;
    req_ch.block_index = idx;
    req_ch.size_value  = sz;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // drain results, then let a trailing load or write-back finish
  task automatic settle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // stimulus
  initial begin
    logic [SizeW-1:0] dir_sizes [NumBlocks];
    logic [ModeW-1:0] modes [NumPhases];
    int               counts [NumPhases];
    bit               idles [NumPhases];
    int               size_top;
    logic [SizeW-1:0] want;

    req_ch.valid       = 1'b0;
    req_ch.req_type    = ReqLoad;
    req_ch.block_index = '0;
    req_ch.size_value  = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    stall_on           = 1'b0;
    quiet_cycles       = 0;
    rst_n              = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: fill every partition, then edge-case requests under first fit
    dir_sizes = '{16'd0, 16'hFFFF, 16'd100, 16'd100, 16'd7, 16'd1, 16'h8000, 16'd0,
                  16'd500, 16'd500, 16'd12345, 16'd2, 16'hFFFE, 16'd40, 16'd40, 16'd9};
    set_config(FitFirst, CountW'(NumBlocks));
    for (int i = 0; i < NumBlocks; i++) begin
      send_item(ReqLoad, i[3:0], dir_sizes[i]);
    end
    // zero request lands on an empty partition
    send_item(ReqAlloc, 4'd0, 16'd0);
    // exact fit empties the full-size partition
    send_item(ReqAlloc, 4'd5, 16'hFFFF);
    // nothing that large is left
    send_item(ReqAlloc, 4'd15, 16'hFFFF);
    send_item(ReqAlloc, 4'd0, 16'd1);
    send_item(ReqAlloc, 4'd0, 16'd99);
    send_item(ReqAlloc, 4'd0, 16'd40000);

    // phase plan: every mode, count extremes, saturation, random counts
    modes  = '{FitFirst, FitBest, FitWorst, FitUnused, FitBest, FitWorst,
               FitFirst, FitBest, FitWorst, FitFirst, FitBest, FitWorst};
    counts = '{NumBlocks, NumBlocks, NumBlocks, NumBlocks, 1, 0,
               CountMax, 0, 0, 0, NumBlocks, NumBlocks};
    counts[7] = $urandom_range(2, NumBlocks - 1);
    counts[8] = $urandom_range(1, NumBlocks);
    counts[9] = $urandom_range(17, CountMax);
    idles  = '{1, 1, 0, 1, 1, 1, 1, 0, 1, 1, 0, 0};

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      stall_on = idles[p];
      set_config(modes[p], CountW'(counts[p]));
      // narrow sizes make equal free sizes, and so ties, common
      size_top = (p % 3 == 0) ? 65535 : 31;
      for (int i = 0; i < NumBlocks; i++) begin
        send_item(ReqLoad, i[3:0], SizeW'($urandom_range(0, size_top)));
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(ReqLoad, 4'($urandom_range(0, NumBlocks - 1)),
                    SizeW'($urandom_range(0, size_top)));
        end else begin
          case ($urandom_range(0, 7))
            0:       want = '0;
            1:       want = SizeW'($urandom_range(0, 65535));
            default: want = SizeW'($urandom_range(0, size_top));
          endcase
          send_item(ReqAlloc, 4'($urandom_range(0, 15)), want);
        end
      end
    end

    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
